// ===== src/ppi_pkg.sv =====
// Shared types, constants and rounding helpers of the planar pose integrator.
// Used by ppi_cordic and planar_pose_integrator; depends on nothing else.
package ppi_pkg;

  // Q1.30 unity and CORDIC start gain
  localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // round(2^32 / pi), as a positive 33-bit multiplier operand
  localparam logic signed [32:0] INV_PI_Q32 = 33'sd1367130551;

  // Largest number of CORDIC iterations and the width of the step index
  localparam int unsigned CORDIC_MAX_STEPS = 32;
  localparam int unsigned STEP_W           = 5;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } cordic_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_OMDT,
    S_ABS,
    S_MUL_HI,
    S_MUL_LO,
    S_TURN_SUM,
    S_HEAD,
    S_CSTART,
    S_CWAIT,
    S_M_SC,
    S_M_CC,
    S_M_SS,
    S_C2,
    S_C2R,
    S_M_V1,
    S_M_V2,
    S_TCOMB,
    S_TR,
    S_M_TH,
    S_M_TL,
    S_TSUM,
    S_DR,
    S_PUPD,
    S_OUT
  } ppi_state_e;

  // Arithmetic right shift by n with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned n);
    logic signed [63:0] half;
    logic signed [63:0] t;
    half = 64'sd1 <<< (n - 1);
    t    = v + half;
    if (v[63]) begin
      t = t - 64'sd1;
    end
    return t >>> n;
  endfunction

  // Clamp a value to the closed range of plus and minus one in Q1.30.
  function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ppi_mul.sv =====
// Shared signed multiplier of the planar pose integrator, product registered.
// Depends on nothing beyond its ports.
module ppi_mul (
  input  logic               clk_i,
  input  logic signed [32:0] op_a_i,
  input  logic signed [32:0] op_b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;
  logic signed [65:0] prod_d;

  assign prod_d = 66'(op_a_i) * 66'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== src/ppi_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine of a full-turn binary angle.
// Depends on ppi_pkg for the gain, the state type and the Q1.30 clamp.
module ppi_cordic import ppi_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned N_STEPS =
    (CORDIC_STEPS < CORDIC_MAX_STEPS) ? CORDIC_STEPS : CORDIC_MAX_STEPS;

  // Arctangent of 2^-i in units where 2^32 is one full turn.
  localparam logic [31:0] ATAN_TURN [CORDIC_MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  cordic_state_e      state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;

  logic signed [33:0] z_init, z_adj;
  logic               flip_init;
  logic signed [33:0] x_sh, y_sh, atan_s;
  logic signed [33:0] x_fin, y_fin;
  logic               last_step;

  // Fold angles beyond a quarter turn back by half a turn; the result is negated.
  always_comb begin
    z_init    = {{2{angle_i[31]}}, angle_i};
    z_adj     = z_init;
    flip_init = 1'b0;
    if (z_init > 34'sd1073741824) begin
      z_adj     = z_init - 34'sd2147483648;
      flip_init = 1'b1;
    end else if (z_init < -34'sd1073741824) begin
      z_adj     = z_init + 34'sd2147483648;
      flip_init = 1'b1;
    end
  end

  assign x_sh      = x_q >>> step_q;
  assign y_sh      = y_q >>> step_q;
  assign atan_s    = {2'b00, ATAN_TURN[step_q]};
  assign last_step = (step_q == STEP_W'(N_STEPS - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = C_RUN;
          step_d  = '0;
        end
      end
      C_RUN: begin
        if (last_step) begin
          state_d = C_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      C_FIN: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= z_adj;
      flip_q <= flip_init;
    end else if (state_q == C_RUN) begin
      if (!z_q[33]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_s;
      end
    end
  end

  assign x_fin  = flip_q ? -x_q : x_q;
  assign y_fin  = flip_q ? -y_q : y_q;
  assign done_o = (state_q == C_FIN);
  assign cos_o  = clamp_q30({{30{x_fin[33]}}, x_fin});
  assign sin_o  = clamp_q30({{30{y_fin[33]}}, y_fin});

endmodule

// ===== src/planar_pose_integrator.sv =====
// Planar pose integrator, top level: sequencer, datapath registers and output register.
// Depends on ppi_pkg, ppi_mul and ppi_cordic.
//
// Dead-reckoning odometry for a holonomic base. Each input transaction carries the body
// velocities vel_x and vel_y, the yaw rate (all signed with POSE_FRAC_BITS fraction bits)
// and the tick length in seconds as unsigned Q0.24. The heading is first advanced by
// yaw rate times tick length, held as a 32-bit binary angle in which the full range is
// four pi, so that the half-angle quaternion wraps exactly. The sine and cosine of half
// the heading come from an iterative CORDIC; the full-angle sine and cosine follow by the
// double-angle identities. The body velocity is rotated by the heading, scaled by the tick
// and added to the position, which saturates at the signed 32-bit limits. Every input
// transaction yields exactly one output transaction with the new pose, the heading and
// the quaternion pair quat_z = sin(heading/2), quat_w = cos(heading/2) in Q1.30. All
// products go through a single shared 33 by 33 bit multiplier with a registered result,
// and the CORDIC performs one micro-rotation per cycle. A new transaction is taken only
// once the previous one is finished: the sequence runs 29 multiplier and rounding steps
// and the CORDIC iterations, plus the steps that start the CORDIC, collect its result,
// load the output register and take the next transaction. in_stall_o is high while an
// item is in progress and while a finished result waits for the output register to
// free. Position and heading reset to zero.
module planar_pose_integrator import ppi_pkg::*; #(
  parameter int unsigned CORDIC_STEPS   = 24,
  parameter int unsigned POSE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic [23:0]        tick_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o
);

  // The heading increment is (|yaw_rate * tick| * round(2^32/pi)) >> (POSE_FRAC_BITS + 26).
  // The low half of that product is first dropped by 32 bits, leaving this shift.
  localparam int unsigned TURN_SHIFT = POSE_FRAC_BITS - 6;
  localparam logic signed [63:0] TURN_HALF = 64'sd1 <<< (POSE_FRAC_BITS - 7);

  ppi_state_e state_q, state_d;

  // Latched input transaction
  logic signed [31:0] vx_q, vy_q, yaw_q;
  logic [23:0]        dt_q;

  // Working registers
  logic               neg_q;
  logic [55:0]        mag_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] hs_q, hc_q;
  logic signed [31:0] s2_q, c2_q;
  logic signed [39:0] t_q;
  logic signed [33:0] d_q;
  logic               sel_y_q;

  // Architectural state
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0]        heading_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_qz_q, out_qw_q;
  logic [31:0]        out_head_q;

  // Shared multiplier and CORDIC
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [31:0] cordic_sin, cordic_cos;

  logic               in_accept;
  logic               load_out;
  logic signed [63:0] rnd24, rnd30, rnd_dbl;
  logic [31:0]        turn_inc;
  logic signed [34:0] pos_sum;
  logic signed [31:0] pos_sel, pos_sat;
  logic signed [55:0] prod56;

  ppi_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  ppi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (heading_q),
    .done_o  (cordic_done),
    .sin_o   (cordic_sin),
    .cos_o   (cordic_cos)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);

  assign rnd24    = rnd_shift(acc_q, 24);
  assign rnd30    = rnd_shift(acc_q, 30);
  assign rnd_dbl  = rnd_shift({prod[62:0], 1'b0}, 30);
  assign turn_inc = acc_q[TURN_SHIFT +: 32];
  assign prod56   = prod[55:0];

  // Saturating position update for whichever axis is being worked on.
  assign pos_sel = sel_y_q ? pos_y_q : pos_x_q;
  assign pos_sum = {{3{pos_sel[31]}}, pos_sel} + {d_q[33], d_q};
  always_comb begin
    if (pos_sum > 35'sd2147483647) begin
      pos_sat = 32'sh7FFF_FFFF;
    end else if (pos_sum < -35'sd2147483648) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // Sequencer: next state, multiplier operands and strobes.
  always_comb begin
    state_d      = state_q;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL_OMDT;
        end
      end
      S_MUL_OMDT: begin
        mul_a   = {yaw_q[31], yaw_q};
        mul_b   = {9'd0, dt_q};
        state_d = S_ABS;
      end
      S_ABS: begin
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        mul_a   = {9'd0, mag_q[55:32]};
        mul_b   = INV_PI_Q32;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        mul_a   = {1'b0, mag_q[31:0]};
        mul_b   = INV_PI_Q32;
        state_d = S_TURN_SUM;
      end
      S_TURN_SUM: begin
        state_d = S_HEAD;
      end
      S_HEAD: begin
        state_d = S_CSTART;
      end
      S_CSTART: begin
        cordic_start = 1'b1;
        state_d      = S_CWAIT;
      end
      S_CWAIT: begin
        if (cordic_done) begin
          state_d = S_M_SC;
        end
      end
      S_M_SC: begin
        mul_a   = {hs_q[31], hs_q};
        mul_b   = {hc_q[31], hc_q};
        state_d = S_M_CC;
      end
      S_M_CC: begin
        mul_a   = {hc_q[31], hc_q};
        mul_b   = {hc_q[31], hc_q};
        state_d = S_M_SS;
      end
      S_M_SS: begin
        mul_a   = {hs_q[31], hs_q};
        mul_b   = {hs_q[31], hs_q};
        state_d = S_C2;
      end
      S_C2: begin
        state_d = S_C2R;
      end
      S_C2R: begin
        state_d = S_M_V1;
      end
      S_M_V1: begin
        mul_a   = {vx_q[31], vx_q};
        mul_b   = sel_y_q ? {s2_q[31], s2_q} : {c2_q[31], c2_q};
        state_d = S_M_V2;
      end
      S_M_V2: begin
        mul_a   = {vy_q[31], vy_q};
        mul_b   = sel_y_q ? {c2_q[31], c2_q} : {s2_q[31], s2_q};
        state_d = S_TCOMB;
      end
      S_TCOMB: begin
        state_d = S_TR;
      end
      S_TR: begin
        state_d = S_M_TH;
      end
      S_M_TH: begin
        mul_a   = {{25{t_q[39]}}, t_q[39:32]};
        mul_b   = {9'd0, dt_q};
        state_d = S_M_TL;
      end
      S_M_TL: begin
        mul_a   = {1'b0, t_q[31:0]};
        mul_b   = {9'd0, dt_q};
        state_d = S_TSUM;
      end
      S_TSUM: begin
        state_d = S_DR;
      end
      S_DR: begin
        state_d = S_PUPD;
      end
      S_PUPD: begin
        state_d = sel_y_q ? S_OUT : S_M_V1;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, pose accumulators and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_y_q     <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        sel_y_q <= 1'b0;
      end else if (state_q == S_PUPD) begin
        sel_y_q <= 1'b1;
      end
      if (state_q == S_HEAD) begin
        heading_q <= neg_q ? (heading_q - turn_inc) : (heading_q + turn_inc);
      end
      if (state_q == S_PUPD) begin
        if (sel_y_q) begin
          pos_y_q <= pos_sat;
        end else begin
          pos_x_q <= pos_sat;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vx_q  <= vel_x_i;
      vy_q  <= vel_y_i;
      yaw_q <= yaw_rate_i;
      dt_q  <= tick_length_i;
    end
    unique case (state_q)
      S_ABS: begin
        // Rounding of the heading increment is on the magnitude.
        neg_q <= prod56[55];
        mag_q <= prod56[55] ? 56'(-prod56) : 56'(prod56);
      end
      S_MUL_LO: begin
        acc_q <= prod[63:0];
      end
      S_TURN_SUM: begin
        acc_q <= acc_q + {32'd0, prod[63:32]} + TURN_HALF;
      end
      S_CWAIT: begin
        if (cordic_done) begin
          hs_q <= cordic_sin;
          hc_q <= cordic_cos;
        end
      end
      S_M_CC: begin
        s2_q <= clamp_q30(rnd_dbl);
      end
      S_M_SS: begin
        acc_q <= prod[63:0];
      end
      S_C2: begin
        acc_q <= acc_q - prod[63:0];
      end
      S_C2R: begin
        c2_q <= clamp_q30(rnd30);
      end
      S_M_V2: begin
        acc_q <= prod[63:0];
      end
      S_TCOMB: begin
        acc_q <= sel_y_q ? (acc_q + prod[63:0]) : (acc_q - prod[63:0]);
      end
      S_TR: begin
        t_q <= rnd24[39:0];
      end
      S_M_TL: begin
        // Upper part of the velocity step times the tick, weighted by 2^32.
        acc_q <= {prod[31:0], 32'd0};
      end
      S_TSUM: begin
        acc_q <= acc_q + prod[63:0];
      end
      S_DR: begin
        d_q <= rnd30[33:0];
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_head_q <= heading_q;
      out_qz_q   <= hs_q;
      out_qw_q   <= hc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_head_q;
  assign quat_z_o    = out_qz_q;
  assign quat_w_o    = out_qw_q;

endmodule

// ===== sim/planar_pose_integrator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for planar_pose_integrator: directed and random odometry ticks.
// Depends on the RTL top level only; builds its own bit-exact pose predictor.
module planar_pose_integrator_tb;

  localparam int unsigned CORDIC_STEPS   = 24;
  localparam int unsigned POSE_FRAC_BITS = 16;
  // The drain time is twice the spacing of transactions at the block's full rate, which is
  // ample for anything still in flight to appear at the output.
  localparam int unsigned DRAIN_CYCLES   = 2 * (CORDIC_STEPS + 33);
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  // Fixed-point constants of the arithmetic: unity and CORDIC gain in Q1.30, round(2^32/pi)
  // and a half turn of the full-turn binary angle.
  localparam longint          UNIT_Q30    = 64'sd1073741824;
  localparam longint          CORDIC_GAIN = 64'sd652032874;
  localparam longint unsigned TURNS_PER_PI = 64'd1367130551;
  localparam longint          HALF_TURN   = 64'sd2147483648;
  localparam longint          POS_MAX     = 64'sd2147483647;
  localparam longint          POS_MIN     = -64'sd2147483648;

  // One input transaction: body velocities, yaw rate and tick length.
  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic [23:0]        tick;
  } motion_t;

  // One output transaction: pose, heading and half-angle quaternion pair.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } pose_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] vel_x_i       = '0;
  logic signed [31:0] vel_y_i       = '0;
  logic signed [31:0] yaw_rate_i    = '0;
  logic [23:0]        tick_length_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic [31:0]        heading_o;
  logic signed [31:0] quat_z_o;
  logic signed [31:0] quat_w_o;

  planar_pose_integrator #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POSE_FRAC_BITS(POSE_FRAC_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .yaw_rate_i   (yaw_rate_i),
    .tick_length_i(tick_length_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .heading_o    (heading_o),
    .quat_z_o     (quat_z_o),
    .quat_w_o     (quat_w_o)
  );

  always #1 clk_i = ~clk_i;

  // Arctangent of 2^-i as a fraction of a full turn, scaled so that 2^32 is one turn.
  int atan_turn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  motion_t motion_q[$];     // transactions still to be offered to the block
  pose_t   pose_expect_q[$]; // predicted poses not yet seen at the output

  // The predictor's own copy of the integrator state.
  logic signed [31:0] est_x       = '0;
  logic signed [31:0] est_y       = '0;
  logic [31:0]        est_heading = '0;

  int unsigned n_queued;
  int unsigned n_presented    = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_results      = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned unexpected_cnt = 0;
  int unsigned zero_tick_cnt  = 0;
  int unsigned saturated_cnt  = 0;
  int unsigned past_pi_cnt    = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_burst    = 0;
  int unsigned send_roll;
  int unsigned stall_roll;
  motion_t     next_motion;
  pose_t       next_pose;
  pose_t       seen_pose;
  pose_t       want_pose;
  logic [4:0]  wrong_fields;

  // Randomised idling is switched off for a stretch in the middle of the run, so that
  // back-to-back transactions on both sides are exercised as well.
  logic calm;
  assign calm = (n_accepted >= 900) && (n_accepted < 1200);

  // Shift right by n bits with rounding half away from zero.
  function automatic longint round_away(longint v, int unsigned n);
    longint half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT_Q30) begin
      return UNIT_Q30;
    end else if (v < -UNIT_Q30) begin
      return -UNIT_Q30;
    end
    return v;
  endfunction

  function automatic longint saturate_pos(longint v);
    if (v > POS_MAX) begin
      saturated_cnt++;
      return POS_MAX;
    end else if (v < POS_MIN) begin
      saturated_cnt++;
      return POS_MIN;
    end
    return v;
  endfunction

  // Advances the predicted pose by one tick and returns the pose the block should report.
  function automatic pose_t advance_pose(motion_t m);
    longint          vx, vy, om, dt, prod, z, x, y, t, hs, hc, s2, c2, tx, ty;
    longint unsigned mag, turn;
    logic            flip;
    int unsigned     i;
    pose_t           p;
    vx = longint'(m.vel_x);
    vy = longint'(m.vel_y);
    om = longint'(m.yaw_rate);
    dt = longint'(m.tick);
    if (m.tick == '0) begin
      zero_tick_cnt++;
    end

    // Heading increment: the exact product times round(2^32/pi), shifted down by
    // POSE_FRAC_BITS + 26 with rounding on the magnitude, then wrapped to 32 bits.
    prod = om * dt;
    mag  = (prod < 0) ? -prod : prod;
    turn = (mag >> 32) * TURNS_PER_PI
         + (((mag & 64'hFFFF_FFFF) * TURNS_PER_PI) >> 32)
         + (64'd1 << (POSE_FRAC_BITS - 7));
    turn = turn >> (POSE_FRAC_BITS - 6);
    if (prod < 0) begin
      turn = -turn;
    end
    est_heading = est_heading + 32'(turn);

    // The heading word read as a signed full-turn angle is half the heading. Beyond a
    // quarter turn it is folded back by half a turn and the vector negated afterwards.
    z    = longint'($signed(est_heading));
    flip = 1'b0;
    if (z > UNIT_Q30) begin
      z    = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -UNIT_Q30) begin
      z    = z + HALF_TURN;
      flip = 1'b1;
    end
    if (flip) begin
      past_pi_cnt++;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z = z - longint'(atan_turn[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z = z + longint'(atan_turn[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    hc = clamp_unit(x);
    hs = clamp_unit(y);

    // Full-angle sine and cosine by the double-angle identities.
    s2 = clamp_unit(round_away(2 * hs * hc, 30));
    c2 = clamp_unit(round_away(hc * hc - hs * hs, 30));

    // Rotate the body velocity into the world frame, scale by the tick and integrate.
    tx    = round_away(vx * c2 - vy * s2, 24);
    ty    = round_away(vx * s2 + vy * c2, 24);
    est_x = 32'(saturate_pos(longint'(est_x) + round_away(tx * dt, 30)));
    est_y = 32'(saturate_pos(longint'(est_y) + round_away(ty * dt, 30)));

    p.pos_x   = est_x;
    p.pos_y   = est_y;
    p.heading = est_heading;
    p.quat_z  = 32'(hs);
    p.quat_w  = 32'(hc);
    return p;
  endfunction

  function automatic void queue_motion(logic signed [31:0] vx, logic signed [31:0] vy,
                                       logic signed [31:0] om, logic [23:0] dt);
    motion_t m;
    m.vel_x    = vx;
    m.vel_y    = vy;
    m.yaw_rate = om;
    m.tick     = dt;
    motion_q = {motion_q, m};
  endfunction

  // Uniform magnitude up to lim with a random sign.
  function automatic logic signed [31:0] signed_up_to(int unsigned lim);
    logic signed [31:0] v;
    v = $urandom_range(0, lim);
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // One of the corner values of a 32-bit signed field, or now and then a random word.
  function automatic logic signed [31:0] extreme_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Cycle counter and watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles with %0d of %0d transactions accepted",
               cycle_cnt, n_accepted, n_queued);
      $display("status: fail");
      $finish;
    end
  end

  // Driver. Inputs change on the falling edge only. A new transaction is offered once
  // the previous one has been accepted; an offered transaction is held, unchanged, until
  // the block takes it. Idle cycles and occasional idle bursts vary the phase at which
  // the next transaction turns up relative to the block's internal sequence.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || n_accepted == n_presented)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        send_roll = $urandom_range(0, 99);
        if (!calm && send_roll == 0) begin
          send_gap = $urandom_range(1, 12);
        end
        if (motion_q.size() == 0 || (!calm && send_roll < 10)) begin
          in_valid_i <= 1'b0;
        end else begin
          next_motion = motion_q.pop_front();
          in_valid_i    <= 1'b1;
          vel_x_i       <= next_motion.vel_x;
          vel_y_i       <= next_motion.vel_y;
          yaw_rate_i    <= next_motion.yaw_rate;
          tick_length_i <= next_motion.tick;
          n_presented++;
        end
      end
    end
  end

  // Output back-pressure: single stall cycles at random plus the odd longer burst, so
  // that the finished result has to wait in the output register at various points.
  always @(negedge clk_i) begin
    if (stall_burst > 0) begin
      stall_burst--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll == 0) begin
        stall_burst = $urandom_range(1, 12);
      end
      out_stall_i <= (stall_roll < 10);
    end
  end

  // Monitor. On every rising edge an accepted input transaction is run through the
  // predictor, and an accepted output transaction is compared with the oldest prediction.
  // The result of an input can never leave in the cycle it is accepted, so the order of
  // the two checks below does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        next_motion.vel_x    = vel_x_i;
        next_motion.vel_y    = vel_y_i;
        next_motion.yaw_rate = yaw_rate_i;
        next_motion.tick     = tick_length_i;
        next_pose            = advance_pose(next_motion);
        pose_expect_q        = {pose_expect_q, next_pose};
        n_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        seen_pose.pos_x   = pos_x_o;
        seen_pose.pos_y   = pos_y_o;
        seen_pose.heading = heading_o;
        seen_pose.quat_z  = quat_z_o;
        seen_pose.quat_w  = quat_w_o;
        if (pose_expect_q.size() == 0) begin
          unexpected_cnt++;
          $display("result %0d arrived with no transaction outstanding", n_results);
        end else begin
          want_pose    = pose_expect_q.pop_front();
          wrong_fields = {want_pose.pos_x   !== seen_pose.pos_x,
                          want_pose.pos_y   !== seen_pose.pos_y,
                          want_pose.heading !== seen_pose.heading,
                          want_pose.quat_z  !== seen_pose.quat_z,
                          want_pose.quat_w  !== seen_pose.quat_w};
          if (wrong_fields != '0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("result %0d wrong in x,y,heading,qz,qw = %b", n_results,
                       wrong_fields);
              $display("  expected x %0d y %0d heading %h qz %0d qw %0d",
                       want_pose.pos_x, want_pose.pos_y, want_pose.heading,
                       want_pose.quat_z, want_pose.quat_w);
              $display("  actual   x %0d y %0d heading %h qz %0d qw %0d",
                       seen_pose.pos_x, seen_pose.pos_y, seen_pose.heading,
                       seen_pose.quat_z, seen_pose.quat_w);
            end
          end
        end
      end
    end
  end

  // Stimulus, reset and the final verdict.
  initial begin
    motion_t     m;
    int unsigned cls;
    int unsigned k;

    // Directed ticks. A zero tick must leave the pose alone whatever the velocities.
    queue_motion(32'sd0, 32'sd0, 32'sd0, 24'd0);
    queue_motion(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'd0);
    // Half a metre forward, then sideways, at heading zero.
    queue_motion(32'sd65536, 32'sd0, 32'sd0, 24'h80_0000);
    queue_motion(32'sd0, -32'sd65536, 32'sd0, 24'h80_0000);
    // Turn by about a quarter turn, drive forward, then on past pi and drive again.
    queue_motion(32'sd0, 32'sd0, 32'sd102944, 24'hFF_FFFF);
    queue_motion(32'sd131072, 32'sd65536, 32'sd0, 24'h40_0000);
    queue_motion(32'sd0, 32'sd0, 32'sd205887, 24'hFF_FFFF);
    queue_motion(32'sd131072, -32'sd65536, 32'sd1, 24'h40_0000);
    // Largest yaw increments either way: the increment exceeds 32 bits and wraps.
    queue_motion(32'sd0, 32'sd0, 32'sh7FFF_FFFF, 24'hFF_FFFF);
    queue_motion(32'sd0, 32'sd0, 32'sh8000_0000, 24'hFF_FFFF);
    queue_motion(32'sd0, 32'sd0, -32'sd1, 24'd1);
    queue_motion(32'sd0, 32'sd0, 32'sd1, 24'hFF_FFFF);
    // Back to a heading of exactly zero is not guaranteed; drive hard to saturate each
    // coordinate at both limits, whatever the heading happens to be.
    for (k = 0; k < 3; k++) begin
      queue_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 24'hFF_FFFF);
    end
    for (k = 0; k < 3; k++) begin
      queue_motion(32'sh8000_0000, 32'sh8000_0000, 32'sd0, 24'hFF_FFFF);
    end
    queue_motion(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF);
    queue_motion(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1);
    queue_motion(-32'sd1, -32'sd1, -32'sd1, 24'hFF_FFFF);

    // Random ticks. Nearly half look like a real base at tick lengths of one to twenty
    // milliseconds; the rest reach the full field ranges, zero ticks, fast spins and saturating moves.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      cls = $urandom_range(0, 99);
      if (cls < 45) begin
        m.vel_x    = signed_up_to(5 * 65536);
        m.vel_y    = signed_up_to(5 * 65536);
        m.yaw_rate = signed_up_to(4 * 65536);
        m.tick     = 24'($urandom_range(16777, 335544));
      end else if (cls < 60) begin
        m.vel_x    = $urandom;
        m.vel_y    = $urandom;
        m.yaw_rate = $urandom;
        m.tick     = 24'($urandom);
      end else if (cls < 70) begin
        m.vel_x    = $urandom;
        m.vel_y    = $urandom;
        m.yaw_rate = signed_up_to(8 * 65536);
        m.tick     = 24'($urandom_range(24'h80_0000, 24'hFF_FFFF));
      end else if (cls < 78) begin
        m.vel_x    = $urandom;
        m.vel_y    = $urandom;
        m.yaw_rate = $urandom;
        m.tick     = 24'd0;
      end else if (cls < 88) begin
        m.vel_x    = signed_up_to(2 * 65536);
        m.vel_y    = signed_up_to(2 * 65536);
        m.yaw_rate = $urandom;
        m.tick     = 24'($urandom_range(24'h40_0000, 24'hFF_FFFF));
      end else begin
        m.vel_x    = extreme_word();
        m.vel_y    = extreme_word();
        m.yaw_rate = extreme_word();
        case ($urandom_range(0, 3))
          0: m.tick = 24'd0;
          1: m.tick = 24'hFF_FFFF;
          2: m.tick = 24'd1;
          default: m.tick = 24'($urandom);
        endcase
      end
      motion_q = {motion_q, m};
    end
    n_queued = motion_q.size();

    // Asynchronous reset held low at start-up and released on a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_queued || pose_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Let the block run on a while longer so that a spurious extra result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d ticks: %0d with zero length, %0d saturated coordinates,", n_accepted,
             zero_tick_cnt, saturated_cnt);
    $display("%0d with heading past pi; %0d mismatches, %0d unexpected, %0d missing",
             past_pi_cnt, mismatch_cnt, unexpected_cnt, pose_expect_q.size());
    if (mismatch_cnt == 0 && unexpected_cnt == 0 && pose_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
